// ===== sv/emd_pkg.sv =====
// ----------------------------------------------------------------------------
// emd_pkg
// Shared types and constants for the encoder-movement to MIDI translator.
// ----------------------------------------------------------------------------
package emd_pkg;

  // MIDI status codes, channel ORed into the low nibble
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_CONTROL  = 8'hB0;

  localparam logic [6:0] REL_UP     = 7'd65;
  localparam logic [6:0] REL_DOWN   = 7'd63;
  localparam logic [6:0] POS_MAX    = 7'd127;
  localparam logic [6:0] POS_MIN    = 7'd0;
  localparam logic [6:0] NOTE_VEL   = 7'd100;
  localparam logic [6:0] NOTE_LIMIT = 7'd63;
  localparam logic [6:0] POS_RESET  = 7'd64;
  localparam logic [6:0] VEL_ZERO   = 7'd0;

  // configuration register indexes (word address)
  localparam logic [1:0] REG_CHANNEL  = 2'd0;
  localparam logic [1:0] REG_RELATIVE = 2'd1;
  localparam logic [1:0] REG_NOTE     = 2'd2;
  localparam logic [1:0] REG_NUMBERS  = 2'd3;

  // output message queue
  localparam int MSG_DEPTH = 4;
  localparam int MSG_AW    = 2;
  localparam int MSG_CW    = 3;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic       held;
    logic [6:0] pos;
  } enc_state_t;

endpackage

// ===== sv/encoder_delta_to_midi.sv =====
// ----------------------------------------------------------------------------
// encoder_delta_to_midi
// Each request names an encoder and a signed detent count and turns into zero,
// one or two MIDI messages on the out_ channel, the final one flagged by
// out_last. A request is accepted every cycle while the message queue has room
// for two messages; the per-encoder state is read on acceptance and written
// back as the request leaves stage 1, with forwarding so back-to-back requests
// on the same encoder see the updated position. The sustained rate is set by
// the output port at one message per cycle while out_ready is high; a relative
// note gives two messages (note-on and note-off), other requests one or none.
// A request passes the stage 1 register and then the message queue before its
// first message appears on the out_ channel. State needs no clearing pass
// after reset. Configuration is written through the APB-style port.
// ----------------------------------------------------------------------------
module encoder_delta_to_midi #(
  parameter int ENCODERS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_encoder,
  input  logic signed [7:0] in_delta,
  // message channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_status_byte,
  output logic [6:0]        out_data_one,
  output logic [6:0]        out_data_two,
  output logic              out_last,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

  // configuration registers
  logic [3:0]  chan_r;
  logic [3:0]  rel_mask_r;
  logic [3:0]  note_mask_r;
  logic [27:0] enc_numbers_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r        <= '0;
      rel_mask_r    <= '0;
      note_mask_r   <= '0;
      enc_numbers_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        emd_pkg::REG_CHANNEL:  chan_r        <= pwdata[3:0];
        emd_pkg::REG_RELATIVE: rel_mask_r    <= pwdata[3:0];
        emd_pkg::REG_NOTE:     note_mask_r   <= pwdata[3:0];
        emd_pkg::REG_NUMBERS:  enc_numbers_r <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      emd_pkg::REG_CHANNEL:  prdata = {28'd0, chan_r};
      emd_pkg::REG_RELATIVE: prdata = {28'd0, rel_mask_r};
      emd_pkg::REG_NOTE:     prdata = {28'd0, note_mask_r};
      emd_pkg::REG_NUMBERS:  prdata = {4'd0, enc_numbers_r};
      default:               prdata = '0;
    endcase
  end

  // stage 1: request waiting on its state read
  logic              s1_valid_r;
  logic [1:0]        s1_enc_r;
  logic signed [7:0] s1_delta_r;
  logic              s1_fire;
  logic              in_acc;
  logic              in_enc_ok;
  logic              fifo_room;

  assign s1_fire   = s1_valid_r && fifo_room;
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_acc    = in_valid && in_ready;
  assign in_enc_ok = ({2'b00, in_encoder} < 4'(ENCODERS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_enc_r   <= in_encoder;
      s1_delta_r <= in_delta;
    end
  end

  // state store
  emd_pkg::enc_state_t cur_st;
  emd_pkg::enc_state_t wr_st;
  logic                wr_en;
  logic [IW-1:0]       s1_idx;

  assign s1_idx = IW'({1'b0, s1_enc_r});

  emd_state_mem #(
    .ENCODERS (ENCODERS),
    .IW       (IW)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc && in_enc_ok),
    .rd_addr   (IW'({1'b0, in_encoder})),
    .rd_data_r (cur_st),
    .wr_en     (wr_en),
    .wr_addr   (s1_idx),
    .wr_data   (wr_st)
  );

  // translate
  logic          s1_active;
  logic          is_note;
  logic          is_rel;
  logic [6:0]    num;
  logic [6:0]    rel_val;
  logic [8:0]    sum;
  logic [6:0]    new_pos;
  logic [7:0]    chan_bits;
  logic          push0;
  logic          push1;
  emd_pkg::msg_t msg0;
  emd_pkg::msg_t msg1;

  assign s1_active = s1_fire && (s1_delta_r != 8'sd0)
                     && ({2'b00, s1_enc_r} < 4'(ENCODERS));
  assign is_note   = note_mask_r[s1_enc_r];
  assign is_rel    = rel_mask_r[s1_enc_r];
  assign num       = enc_numbers_r[7*s1_enc_r +: 7];
  assign rel_val   = s1_delta_r[7] ? emd_pkg::REL_DOWN : emd_pkg::REL_UP;
  assign chan_bits = {4'd0, chan_r};
  assign sum       = {2'b00, cur_st.pos} + {s1_delta_r[7], s1_delta_r};

  // saturate: bit 8 set means negative, bit 7 set means above the top
  always_comb begin
    if (sum[8]) begin
      new_pos = emd_pkg::POS_MIN;
    end else if (sum[7]) begin
      new_pos = emd_pkg::POS_MAX;
    end else begin
      new_pos = sum[6:0];
    end
  end

  always_comb begin
    push0            = 1'b0;
    push1            = 1'b0;
    wr_en            = 1'b0;
    wr_st.pos        = new_pos;
    wr_st.held       = cur_st.held;
    msg0.status_byte = emd_pkg::ST_CONTROL | chan_bits;
    msg0.data_one    = num;
    msg0.data_two    = new_pos;
    msg0.last        = 1'b1;
    msg1.status_byte = emd_pkg::ST_NOTE_OFF | chan_bits;
    msg1.data_one    = num;
    msg1.data_two    = emd_pkg::VEL_ZERO;
    msg1.last        = 1'b1;
    if (s1_active) begin
      if (is_rel) begin
        push0         = 1'b1;
        msg0.data_two = rel_val;
        if (is_note) begin
          push1            = 1'b1;
          msg0.status_byte = emd_pkg::ST_NOTE_ON | chan_bits;
          msg0.last        = 1'b0;
        end
      end else begin
        wr_en = 1'b1;
        if (!is_note) begin
          push0 = 1'b1;
        end else if (new_pos > emd_pkg::NOTE_LIMIT) begin
          if (!cur_st.held) begin
            push0            = 1'b1;
            wr_st.held       = 1'b1;
            msg0.status_byte = emd_pkg::ST_NOTE_ON | chan_bits;
            msg0.data_two    = emd_pkg::NOTE_VEL;
          end
        end else if (cur_st.held) begin
          push0            = 1'b1;
          wr_st.held       = 1'b0;
          msg0.status_byte = emd_pkg::ST_NOTE_OFF | chan_bits;
          msg0.data_two    = emd_pkg::VEL_ZERO;
        end
      end
    end
  end

  emd_pkg::msg_t out_msg;

  emd_msg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .msg0      (msg0),
    .msg1      (msg1),
    .room      (fifo_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_msg   (out_msg)
  );

  assign out_status_byte = out_msg.status_byte;
  assign out_data_one    = out_msg.data_one;
  assign out_data_two    = out_msg.data_two;
  assign out_last        = out_msg.last;

  a_held_above_limit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && is_note && wr_st.held |-> wr_st.pos > emd_pkg::NOTE_LIMIT)
    else $error("held note stored with position at or below limit");

  a_zero_delta_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_delta_r == 8'sd0) |-> !push0 && !push1 && !wr_en)
    else $error("zero move produced output or state change");

  a_note_off_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_byte[7:4] == emd_pkg::ST_NOTE_OFF[7:4])
    |-> out_data_two == emd_pkg::VEL_ZERO)
    else $error("note-off with nonzero velocity");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0 && !msg0.last && msg1.last)
    else $error("second message without a leading first message");

endmodule

// ===== sv/emd_state_mem.sv =====
// ----------------------------------------------------------------------------
// emd_state_mem
// Per-encoder state store: position and held-note flag, registered read,
// write-to-read forwarding, per-entry valid bits standing in for reset.
// ----------------------------------------------------------------------------
module emd_state_mem #(
  parameter int ENCODERS = 4,
  parameter int IW       = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output emd_pkg::enc_state_t rd_data_r,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  emd_pkg::enc_state_t wr_data
);

  emd_pkg::enc_state_t mem_r [ENCODERS];
  logic [ENCODERS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // forward a write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else if (vld_r[rd_addr]) begin
        rd_data_r <= mem_r[rd_addr];
      end else begin
        rd_data_r.held <= 1'b0;
        rd_data_r.pos  <= emd_pkg::POS_RESET;
      end
    end
  end

endmodule

// ===== sv/emd_msg_fifo.sv =====
// ----------------------------------------------------------------------------
// emd_msg_fifo
// Small message queue: up to two pushes a cycle, one pop toward the port.
// ----------------------------------------------------------------------------
module emd_msg_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push0,
  input  logic          push1,
  input  emd_pkg::msg_t msg0,
  input  emd_pkg::msg_t msg1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output emd_pkg::msg_t out_msg
);

  emd_pkg::msg_t                  mem_r [emd_pkg::MSG_DEPTH];
  logic [emd_pkg::MSG_AW-1:0]     wp_r, wp_nxt;
  logic [emd_pkg::MSG_AW-1:0]     rp_r, rp_nxt;
  logic [emd_pkg::MSG_CW-1:0]     cnt_r, cnt_nxt;
  logic [emd_pkg::MSG_CW-1:0]     push_n;
  logic                           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_msg   = mem_r[rp_r];
  // keep space for the largest burst of one request
  assign room      = (cnt_r <= emd_pkg::MSG_CW'(emd_pkg::MSG_DEPTH - 2));

  always_comb begin
    push_n  = emd_pkg::MSG_CW'(push0) + emd_pkg::MSG_CW'(push1);
    wp_nxt  = wp_r + emd_pkg::MSG_AW'(push_n);
    rp_nxt  = rp_r + emd_pkg::MSG_AW'(pop);
    cnt_nxt = cnt_r + push_n - emd_pkg::MSG_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wp_r] <= msg0;
    end
    if (push1) begin
      mem_r[wp_r + emd_pkg::MSG_AW'(1)] <= msg1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= emd_pkg::MSG_CW'(emd_pkg::MSG_DEPTH))
    else $error("message queue overflow");

endmodule
